// ===== hw/rtl/lddt_pkg.sv =====
package lddt_pkg;

   localparam int DIST_W     = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSUM_W     = 15;
   localparam int CCNT_W     = 13;
   localparam int PSUM_W     = 28;
   localparam int PCNT_W     = 11;
   localparam int LSUM_W     = 30;
   localparam int LCNT_W     = 13;
   localparam int SCORE_W    = 17;
   localparam int DIV_NUM_W  = 30;
   localparam int DIV_DEN_W  = 13;
   localparam int DIV_CNT_W  = 5;
   localparam int PTS_W      = 3;
   localparam int Q16_SHIFT  = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 8'd1;

   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd1;

   localparam logic [DIST_W-1:0]  RADIUS_RESET = 16'd3840;
   localparam logic [DIST_W-1:0]  THR_HALF     = 16'd128;
   localparam logic [DIST_W-1:0]  THR_ONE      = 16'd256;
   localparam logic [DIST_W-1:0]  THR_TWO      = 16'd512;
   localparam logic [DIST_W-1:0]  THR_FOUR     = 16'd1024;
   localparam logic [SCORE_W-1:0] ONE_Q16      = 17'd65536;

   typedef enum logic [1:0] {
      DIV_PAIR   = 2'd0,
      DIV_COLUMN = 2'd1,
      DIV_ALIGN  = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        item_load;
      logic        accumulate;
      logic        div_start;
      div_sel_type div_sel;
      logic        pair_update;
      logic        col_update;
      logic        aln_update;
      logic        out_load;
   } lddt_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic present;
      logic end_pair;
      logic end_col;
      logic end_align;
      logic out_free;
   } lddt_sts_type;

endpackage

// ===== hw/rtl/lddt_div.sv =====
module lddt_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lddt_pkg::DIV_NUM_W-1:0]  num,
   input  logic [lddt_pkg::DIV_DEN_W-1:0]  den,
   output logic                            busy,
   output logic                            done,
   output logic [lddt_pkg::SCORE_W-1:0]    quot
);
   import lddt_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      if (den_ff == '0) begin
         quot = '0;
      end else if (quo_ff > DIV_NUM_W'(ONE_Q16)) begin
         quot = ONE_Q16;
      end else begin
         quot = quo_ff[SCORE_W-1:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// ===== hw/rtl/lddt_dpath.sv =====
module lddt_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  lddt_pkg::lddt_cmd_type            cmd,
   output lddt_pkg::lddt_sts_type            sts,
   input  logic [2*lddt_pkg::DIST_W-1:0]     req_tdata,
   input  logic [3:0]                        req_tuser,
   input  logic                              req_tlast,
   input  logic                              csr_valid,
   input  logic [lddt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lddt_pkg::DIST_W-1:0]       csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,
   output logic                              rsp_tlast
);
   import lddt_pkg::*;

   logic [DIST_W-1:0]  radius_ff, radius_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;

   logic [DIST_W-1:0]  da_ff, db_ff;
   logic               valid_ff, present_ff, end_pair_ff, end_col_ff, end_align_ff;

   logic [CSUM_W-1:0]  csum_ff, csum_in;
   logic [CCNT_W-1:0]  ccnt_ff, ccnt_in;
   logic [PSUM_W-1:0]  psum_ff, psum_in;
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic [LSUM_W-1:0]  lsum_ff, lsum_in;
   logic [LCNT_W-1:0]  lcnt_ff, lcnt_in;
   logic [SCORE_W-1:0] cs_ff, as_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_col_ff, rsp_aln_ff;
   logic               rsp_final_ff;

   logic               fa, fb, skip;
   logic [DIST_W-1:0]  diff;
   logic [PTS_W-1:0]   pts;
   logic [CSUM_W:0]    csum_add;
   logic [PSUM_W:0]    psum_add;
   logic [LSUM_W:0]    lsum_add;

   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [SCORE_W-1:0]   div_q;
   logic                 div_busy, div_done;

   always_comb begin
      radius_in = radius_ff;
      mode_in   = mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS: radius_in = csr_data;
            CSR_MODE:   mode_in   = csr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         mode_ff   <= MODE_FIRST;
      end else begin
         radius_ff <= radius_in;
         mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         da_ff        <= req_tdata[DIST_W-1:0];
         db_ff        <= req_tdata[2*DIST_W-1:DIST_W];
         valid_ff     <= req_tuser[0];
         present_ff   <= req_tuser[1];
         end_align_ff <= req_tlast;
         end_col_ff   <= req_tuser[3] | req_tlast;
         end_pair_ff  <= req_tuser[2] | req_tuser[3] | req_tlast;
      end
   end

   assign fa = da_ff > radius_ff;
   assign fb = db_ff > radius_ff;

   always_comb begin
      case (mode_ff)
         MODE_FIRST: skip = fa;
         MODE_BOTH:  skip = fa & fb;
         default:    skip = fa | fb;
      endcase
   end

   assign diff = (da_ff > db_ff) ? da_ff - db_ff : db_ff - da_ff;
   assign pts  = PTS_W'(diff < THR_HALF) + PTS_W'(diff < THR_ONE)
               + PTS_W'(diff < THR_TWO) + PTS_W'(diff < THR_FOUR);

   assign csum_add = {1'b0, csum_ff} + (CSUM_W+1)'(pts);
   assign psum_add = {1'b0, psum_ff} + (PSUM_W+1)'(div_q);
   assign lsum_add = {1'b0, lsum_ff} + (LSUM_W+1)'(div_q);

   always_comb begin
      csum_in = csum_ff;
      ccnt_in = ccnt_ff;
      psum_in = psum_ff;
      pcnt_in = pcnt_ff;
      lsum_in = lsum_ff;
      lcnt_in = lcnt_ff;
      if (cmd.accumulate && valid_ff && present_ff && !skip) begin
         csum_in = csum_add[CSUM_W] ? '1 : csum_add[CSUM_W-1:0];
         ccnt_in = (ccnt_ff == '1) ? ccnt_ff : ccnt_ff + 1'b1;
      end
      if (cmd.pair_update) begin
         csum_in = '0;
         ccnt_in = '0;
         if (present_ff) begin
            psum_in = psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
            pcnt_in = (pcnt_ff == '1) ? pcnt_ff : pcnt_ff + 1'b1;
         end
      end
      if (cmd.col_update) begin
         psum_in = '0;
         pcnt_in = '0;
         lsum_in = lsum_add[LSUM_W] ? '1 : lsum_add[LSUM_W-1:0];
         lcnt_in = (lcnt_ff == '1) ? lcnt_ff : lcnt_ff + 1'b1;
      end
      if (cmd.aln_update) begin
         lsum_in = '0;
         lcnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_ff <= '0;
         ccnt_ff <= '0;
         psum_ff <= '0;
         pcnt_ff <= '0;
         lsum_ff <= '0;
         lcnt_ff <= '0;
      end else begin
         csum_ff <= csum_in;
         ccnt_ff <= ccnt_in;
         psum_ff <= psum_in;
         pcnt_ff <= pcnt_in;
         lsum_ff <= lsum_in;
         lcnt_ff <= lcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.col_update) begin
         cs_ff <= div_q;
      end
      if (cmd.aln_update) begin
         as_ff <= div_q;
      end
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_PAIR: begin
            div_num = {1'b0, csum_ff, Q16_SHIFT'(0)};
            div_den = ccnt_ff;
         end
         DIV_COLUMN: begin
            div_num = DIV_NUM_W'(psum_ff);
            div_den = DIV_DEN_W'(pcnt_ff);
         end
         default: begin
            div_num = lsum_ff;
            div_den = lcnt_ff;
         end
      endcase
   end

   lddt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_col_ff   <= cs_ff;
         rsp_aln_ff   <= end_align_ff ? as_ff : '0;
         rsp_final_ff <= end_align_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_aln_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_final_ff;

   assign sts.div_busy  = div_busy;
   assign sts.div_done  = div_done;
   assign sts.present   = present_ff;
   assign sts.end_pair  = end_pair_ff;
   assign sts.end_col   = end_col_ff;
   assign sts.end_align = end_align_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

// ===== hw/rtl/lddt_ctrl.sv =====
module lddt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output lddt_pkg::lddt_cmd_type  cmd,
   input  lddt_pkg::lddt_sts_type  sts
);
   import lddt_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_ACCUM    = 12'b0000_0000_0010,
      ST_PAIR_GO  = 12'b0000_0000_0100,
      ST_PAIR_DIV = 12'b0000_0000_1000,
      ST_PAIR_UPD = 12'b0000_0001_0000,
      ST_COL_GO   = 12'b0000_0010_0000,
      ST_COL_DIV  = 12'b0000_0100_0000,
      ST_COL_UPD  = 12'b0000_1000_0000,
      ST_ALN_GO   = 12'b0001_0000_0000,
      ST_ALN_DIV  = 12'b0010_0000_0000,
      ST_ALN_UPD  = 12'b0100_0000_0000,
      ST_EMIT     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.div_sel    = DIV_PAIR;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.item_load = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accumulate = 1'b1;
            if (!sts.end_pair) begin
               state_in = ST_IDLE;
            end else if (sts.present) begin
               state_in = ST_PAIR_GO;
            end else begin
               state_in = ST_PAIR_UPD;
            end
         end
         ST_PAIR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_PAIR;
            state_in      = ST_PAIR_DIV;
         end
         ST_PAIR_DIV: begin
            if (sts.div_done) begin
               state_in = ST_PAIR_UPD;
            end
         end
         ST_PAIR_UPD: begin
            cmd.pair_update = 1'b1;
            state_in = sts.end_col ? ST_COL_GO : ST_IDLE;
         end
         ST_COL_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_COLUMN;
            state_in      = ST_COL_DIV;
         end
         ST_COL_DIV: begin
            if (sts.div_done) begin
               state_in = ST_COL_UPD;
            end
         end
         ST_COL_UPD: begin
            cmd.col_update = 1'b1;
            state_in = sts.end_align ? ST_ALN_GO : ST_EMIT;
         end
         ST_ALN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ALIGN;
            state_in      = ST_ALN_DIV;
         end
         ST_ALN_DIV: begin
            if (sts.div_done) begin
               state_in = ST_ALN_UPD;
            end
         end
         ST_ALN_UPD: begin
            cmd.aln_update = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   a_load_free_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over a pending beat");

   a_plain_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && !sts.end_pair) |=> state_ff == ST_IDLE)
      else $error("item without pair end did not return to idle");

   a_done_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> sts.div_busy)
      else $error("divider did not go busy after start");
`endif

endmodule

// ===== hw/rtl/lddt_alignment_scorer.sv =====
// Column-averaged lDDT scorer. Each req beat carries one comparison: two Q8.8
// distances plus flags; a beat is accepted, then accumulated. The end of a
// counted pair, the end of a column and the end of the alignment each run one
// mean through a shared one-bit-per-cycle divider (start, 30 steps, done,
// update). A beat that closes a column may also wait for the output register
// to free up. One rsp beat per column holds the column score and, on the final
// column, the alignment score, both Q1.16 with 65536 meaning 1.0. The output
// register lets the next req beat be taken while a rsp beat waits. Config
// writes are always accepted and must only be issued while the block is idle.
module lddt_alignment_scorer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // distance_a, distance_b
   input  logic [2*lddt_pkg::DIST_W-1:0]     req_tdata,
   // compare_valid, pair_present, last_of_pair, last_of_column
   input  logic [3:0]                        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // column_score, alignment_score, zero fill
   output logic [39:0]                       rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lddt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lddt_pkg::DIST_W-1:0]       csr_data
);
   import lddt_pkg::*;

   lddt_cmd_type cmd;
   lddt_sts_type sts;

   assign csr_ready = 1'b1;

   lddt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   lddt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lddt_pkg::*;

   localparam logic [MODE_W-1:0] MODE_EITHER = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
   localparam int unsigned PHASE_BEATS = 200;
   localparam int unsigned SETTLE_CYCLES = 150;
   localparam int unsigned DRAIN_HOLD_CYCLES = 800;

   typedef struct packed {
      logic [DIST_W-1:0] dist_a;
      logic [DIST_W-1:0] dist_b;
      logic              cmp_valid;
      logic              present;
      logic              end_pair;
      logic              end_col;
      logic              end_aln;
   } comparison_type;

   typedef struct packed {
      logic [SCORE_W-1:0] column_val;
      logic [SCORE_W-1:0] aln_score;
      logic               final_flag;
   } score_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_RADIUS,
      ROW_MODE
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [DIST_W-1:0] csr_value;
      comparison_type    beat;
      logic              typed;
      score_type         want;
   } stim_row_type;

   localparam score_type NO_SCORE = '0;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*DIST_W-1:0]      req_tdata = '0;
   logic [3:0]               req_tuser = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [39:0]              rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DIST_W-1:0]        csr_data = '0;

   lddt_alignment_scorer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scorer state mirror
   logic [DIST_W-1:0] radius_q = RADIUS_RESET;
   logic [MODE_W-1:0] mode_q = MODE_FIRST;
   logic [CSUM_W-1:0] contact_sum = '0;
   logic [CCNT_W-1:0] contact_cnt = '0;
   logic [PSUM_W-1:0] pair_sum = '0;
   logic [PCNT_W-1:0] pair_cnt = '0;
   logic [LSUM_W-1:0] col_sum = '0;
   logic [LCNT_W-1:0] col_cnt = '0;

   score_type   expected_scores [$];
   int unsigned error_count = 0;
   int unsigned beats_sent = 0;
   bit          burst = 1'b0;
   bit          calm = 1'b0;
   bit          drain_hold = 1'b0;

   function automatic logic [31:0] clip_sum(input logic [31:0] acc, input logic [31:0] inc,
                                            input logic [31:0] lim);
      logic [32:0] s;
      s = {1'b0, acc} + {1'b0, inc};
      return (s > {1'b0, lim}) ? lim : s[31:0];
   endfunction

   function automatic logic [SCORE_W-1:0] ratio_q16(input logic [63:0] num,
                                                    input logic [31:0] den);
      logic [63:0] q;
      if (den == 0)
         return '0;
      q = num / den;
      return (q > 64'(ONE_Q16)) ? ONE_Q16 : q[SCORE_W-1:0];
   endfunction

   function automatic bit score_beat(input comparison_type b, output score_type res);
      logic              far_a;
      logic              far_b;
      logic              skip;
      logic              closes_col;
      logic              closes_pair;
      logic [DIST_W-1:0] diff;
      logic [PTS_W-1:0]  pts;
      logic [SCORE_W-1:0] pair_mean;
      logic [SCORE_W-1:0] col_mean;
      res = NO_SCORE;
      closes_col = b.end_col || b.end_aln;
      closes_pair = b.end_pair || closes_col;
      if (b.present && b.cmp_valid) begin
         far_a = b.dist_a > radius_q;
         far_b = b.dist_b > radius_q;
         case (mode_q)
            MODE_FIRST: begin
               skip = far_a;
            end
            MODE_BOTH: begin
               skip = far_a && far_b;
            end
            default: begin
               skip = far_a || far_b;
            end
         endcase
         if (!skip) begin
            diff = (b.dist_a > b.dist_b) ? b.dist_a - b.dist_b : b.dist_b - b.dist_a;
            pts = PTS_W'(diff < THR_HALF) + PTS_W'(diff < THR_ONE)
                + PTS_W'(diff < THR_TWO) + PTS_W'(diff < THR_FOUR);
            contact_sum = CSUM_W'(clip_sum(32'(contact_sum), 32'(pts), (1 << CSUM_W) - 1));
            contact_cnt = CCNT_W'(clip_sum(32'(contact_cnt), 1, (1 << CCNT_W) - 1));
         end
      end
      if (closes_pair) begin
         if (b.present) begin
            pair_mean = ratio_q16(64'(contact_sum) << Q16_SHIFT, 32'(contact_cnt));
            pair_sum = PSUM_W'(clip_sum(32'(pair_sum), 32'(pair_mean), (1 << PSUM_W) - 1));
            pair_cnt = PCNT_W'(clip_sum(32'(pair_cnt), 1, (1 << PCNT_W) - 1));
         end
         contact_sum = '0;
         contact_cnt = '0;
      end
      if (!closes_col)
         return 1'b0;
      col_mean = ratio_q16(64'(pair_sum), 32'(pair_cnt));
      pair_sum = '0;
      pair_cnt = '0;
      col_sum = LSUM_W'(clip_sum(32'(col_sum), 32'(col_mean), (1 << LSUM_W) - 1));
      col_cnt = LCNT_W'(clip_sum(32'(col_cnt), 1, (1 << LCNT_W) - 1));
      res.column_val = col_mean;
      res.final_flag = b.end_aln;
      if (b.end_aln) begin
         res.aln_score = ratio_q16(64'(col_sum), 32'(col_cnt));
         col_sum = '0;
         col_cnt = '0;
      end
      return 1'b1;
   endfunction

   function automatic logic [DIST_W-1:0] jitter(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(2 * spread)) - spread;
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return DIST_W'(v);
   endfunction

   function automatic comparison_type with_distances(input comparison_type b);
      case ($urandom_range(3))
         0: begin
            b.dist_a = DIST_W'($urandom);
            b.dist_b = DIST_W'($urandom);
         end
         1: begin
            b.dist_a = jitter(int'(radius_q), 300);
            b.dist_b = jitter(int'(b.dist_a), 1200);
         end
         2: begin
            b.dist_a = DIST_W'($urandom_range(int'(radius_q)));
            b.dist_b = jitter(int'(b.dist_a), 1200);
         end
         default: begin
            b.dist_a = DIST_W'($urandom);
            b.dist_b = jitter(int'(b.dist_a), 160);
         end
      endcase
      return b;
   endfunction

   // hold valid across back-to-back beats; lower it only when a gap is drawn
   task automatic offer(input comparison_type beat, input logic typed, input score_type want);
      int unsigned gap;
      score_type   res;
      gap = (burst || calm) ? 0 : $urandom_range(17);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {beat.dist_b, beat.dist_a};
      req_tuser <= {beat.end_col, beat.end_pair, beat.present, beat.cmp_valid};
      req_tlast <= beat.end_aln;
      do @(posedge clock); while (!req_tready);
      if (score_beat(beat, res))
         expected_scores.push_back(typed ? want : res);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_scores.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIST_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RADIUS)
         radius_q = value;
      else if (idx == CSR_MODE)
         mode_q = value[MODE_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_alignment();
      int unsigned    ncol;
      int unsigned    npair;
      int unsigned    npass;
      int unsigned    ncmp;
      bit             pres;
      comparison_type b;
      ncol = $urandom_range(1, 4);
      calm = ($urandom_range(5) == 0);
      for (int c = 0; c < ncol; c++) begin
         npair = $urandom_range(0, 4);
         npass = (npair == 0) ? 1 : npair;
         for (int p = 0; p < npass; p++) begin
            pres = (npair != 0) && ($urandom_range(9) != 0);
            ncmp = (npair == 0) ? 1 : $urandom_range(1, 6);
            for (int k = 0; k < ncmp; k++) begin
               b = with_distances('0);
               b.cmp_valid = ($urandom_range(7) != 0);
               b.present = pres;
               b.end_pair = (k == ncmp - 1);
               b.end_col = b.end_pair && (p == npass - 1);
               b.end_aln = b.end_col && (c == ncol - 1);
               if (b.end_col && $urandom_range(3) == 0)
                  b.end_pair = 1'b0;
               if (b.end_aln && $urandom_range(3) == 0)
                  b.end_col = 1'b0;
               if ($urandom_range(19) == 0)
                  {b.cmp_valid, b.present, b.end_pair, b.end_col, b.end_aln} = 5'($urandom);
               offer(b, 1'b0, NO_SCORE);
            end
         end
      end
      calm = 1'b0;
   endtask

   // long back-to-back runs of close contacts, as one pair or one pair per beat
   task automatic send_long_run(input int unsigned n, input bit pair_per_beat);
      comparison_type b;
      burst = 1'b1;
      for (int unsigned k = 0; k < n; k++) begin
         b = '0;
         b.dist_a = DIST_W'($urandom);
         b.dist_b = jitter(int'(b.dist_a), 127);
         b.cmp_valid = 1'b1;
         b.present = 1'b1;
         b.end_pair = pair_per_beat;
         b.end_aln = (k == n - 1);
         offer(b, 1'b0, NO_SCORE);
      end
      burst = 1'b0;
   endtask

   stim_row_type directed_rows [27] = '{
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
        1'b1, '{17'd65536, 17'd0, 1'b0}},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0},
        1'b1, '{17'd0, 17'd0, 1'b0}},
      '{ROW_BEAT, 16'd0, '{16'd65535, 16'd65535, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
        1'b1, '{17'd0, 17'd0, 1'b0}},
      '{ROW_BEAT, 16'd0, '{16'd65535, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd65535, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd3840, 16'd3713, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd3841, 16'd3841, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd1000, 16'd872, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd255, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd256, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd511, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd512, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd1023, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd1024, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd200, 16'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
        1'b1, '{17'd65536, 17'd65536, 1'b1}},
      '{ROW_MODE, 16'(MODE_BOTH), '0, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd4000, 16'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd4000, 16'd4000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd100, 16'd100, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_SCORE},
      '{ROW_MODE, 16'(MODE_SPARE), '0, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd100, 16'd4000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_SCORE},
      '{ROW_RADIUS, 16'd0, '0, 1'b0, NO_SCORE},
      '{ROW_BEAT, 16'd0, '{16'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1},
        1'b1, '{17'd65536, 17'd65536, 1'b1}}
   };

   initial begin : stimulus
      logic [DIST_W-1:0] phase_radius [6];
      logic [MODE_W-1:0] phase_mode [6];
      int unsigned       start;
      phase_radius = '{RADIUS_RESET, 16'd1024, 16'hFFFF, DIST_W'($urandom), 16'd0,
                       DIST_W'($urandom)};
      phase_mode = '{MODE_FIRST, MODE_BOTH, MODE_EITHER, MODE_SPARE, MODE_FIRST,
                     MODE_W'($urandom_range(3))};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_BEAT: begin
               offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
            end
            ROW_RADIUS: begin
               settle();
               write_csr(CSR_RADIUS, directed_rows[i].csr_value);
            end
            default: begin
               settle();
               write_csr(CSR_MODE, directed_rows[i].csr_value);
            end
         endcase
      end
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         write_csr(CSR_RADIUS, phase_radius[ph]);
         write_csr(CSR_MODE, DIST_W'(phase_mode[ph]));
         if (ph == 1)
            drain_hold = 1'b1;
         start = beats_sent;
         while (beats_sent - start < PHASE_BEATS)
            send_alignment();
         if (ph == 2) begin
            send_long_run(200, 1'b0);
            send_long_run(100, 1'b1);
         end
      end
      settle();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : rsp_sink
      int unsigned stall;
      int unsigned calm_left;
      score_type   want;
      calm_left = 0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (drain_hold) begin
            stall = DRAIN_HOLD_CYCLES;
            drain_hold = 1'b0;
         end else if (calm_left != 0) begin
            stall = 0;
            calm_left--;
         end else begin
            stall = $urandom_range(17);
            if ($urandom_range(15) == 0)
               calm_left = $urandom_range(5, 20);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         if (expected_scores.size() == 0) begin
            $error("unexpected result beat: column_score %0d",
                   rsp_tdata[SCORE_W-1:0]);
            error_count++;
         end else begin
            want = expected_scores.pop_front();
            if (rsp_tdata[SCORE_W-1:0] !== want.column_val) begin
               $error("column_score expected %0d actual %0d", want.column_val,
                      rsp_tdata[SCORE_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[2*SCORE_W-1:SCORE_W] !== want.aln_score) begin
               $error("alignment_score expected %0d actual %0d", want.aln_score,
                      rsp_tdata[2*SCORE_W-1:SCORE_W]);
               error_count++;
            end
            if (rsp_tlast !== want.final_flag) begin
               $error("final_res expected %0d actual %0d", want.final_flag, rsp_tlast);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lddt_pkg.sv
hw/rtl/lddt_div.sv
hw/rtl/lddt_dpath.sv
hw/rtl/lddt_ctrl.sv
hw/rtl/lddt_alignment_scorer.sv
tb/testbench.sv
